// File: sv/asc_pkg.sv
// Ascon-128 decryption package: payload types, codes, masks and the round function.
package asc_pkg;

  localparam int LANE_W = 64;
  localparam int NUM_LANES = 5;
  localparam int MAX_ROUNDS = 12;
  localparam int INIT_ROUNDS_DEF = 12;
  localparam int BLOCK_ROUNDS_DEF = 6;
  localparam int BLOCK_BYTES = LANE_W / 8;
  localparam int ROUND_W = 4;

  // operation codes of an input item
  localparam logic [2:0] OP_NONCE_HIGH = 3'd0;
  localparam logic [2:0] OP_NONCE_LOW  = 3'd1;
  localparam logic [2:0] OP_AD         = 3'd2;
  localparam logic [2:0] OP_CT         = 3'd3;
  localparam logic [2:0] OP_TAG_HIGH   = 3'd4;
  localparam logic [2:0] OP_TAG_LOW    = 3'd5;

  // result kinds
  localparam logic [1:0] KIND_PLAIN   = 2'd0;
  localparam logic [1:0] KIND_VERDICT = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // configuration register indexes
  localparam logic REG_KEY_HIGH = 1'b0;
  localparam logic REG_KEY_LOW  = 1'b1;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef logic [NUM_LANES-1:0][LANE_W-1:0] lanes_t;

  typedef struct packed {
    logic [2:0]        operation;
    logic [LANE_W-1:0] data;
    logic [3:0]        valid_bytes;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        result_kind;
    logic [LANE_W-1:0] plaintext;
    logic [3:0]        plain_bytes;
    logic              tag_ok;
  } out_item_t;

  typedef struct packed {
    logic              index;
    logic [LANE_W-1:0] value;
  } cfg_write_t;

  typedef enum logic [2:0] {
    A_NONCE_HIGH,
    A_INIT,
    A_AD,
    A_CT,
    A_FINAL,
    A_TAG,
    A_ERROR
  } action_t;

  typedef struct packed {
    logic                load;
    action_t             action;
    logic                ct_first;
    logic                round_en;
    logic [ROUND_W-1:0]  round_idx;
    logic                post_en;
  } cmd_t;

  // mask of the first n bytes, n clamped to 0..8
  function automatic logic [LANE_W-1:0] byte_mask(input logic [3:0] n);
    logic [LANE_W-1:0] m;
    m = '0;
    for (int b = 0; b < BLOCK_BYTES; b++) begin
      if (4'(b) < n) m[LANE_W-1-8*b -: 8] = 8'hff;
    end
    return m;
  endfunction

  // padding byte at byte position n, n in 0..7
  function automatic logic [LANE_W-1:0] pad_at(input logic [2:0] n);
    logic [LANE_W-1:0] p;
    p = '0;
    for (int b = 0; b < BLOCK_BYTES; b++) begin
      if (3'(b) == n) p[LANE_W-1-8*b -: 8] = PAD_BYTE;
    end
    return p;
  endfunction

  function automatic logic [LANE_W-1:0] rotr(input logic [LANE_W-1:0] x, input int n);
    return (x >> n) | (x << (LANE_W - n));
  endfunction

  // one permutation round with round index r (0..11)
  function automatic lanes_t asc_round(input lanes_t s, input logic [ROUND_W-1:0] r);
    logic [LANE_W-1:0] x0, x1, x2, x3, x4, t0, t1, t2, t3, t4;
    lanes_t o;
    x0 = s[0]; x1 = s[1]; x2 = s[2]; x3 = s[3]; x4 = s[4];
    x2 = x2 ^ {56'd0, 4'd15 - r, r};
    x0 = x0 ^ x4; x4 = x4 ^ x3; x2 = x2 ^ x1;
    t0 = ~x0 & x1; t1 = ~x1 & x2; t2 = ~x2 & x3; t3 = ~x3 & x4; t4 = ~x4 & x0;
    x0 = x0 ^ t1; x1 = x1 ^ t2; x2 = x2 ^ t3; x3 = x3 ^ t4; x4 = x4 ^ t0;
    x1 = x1 ^ x0; x0 = x0 ^ x4; x3 = x3 ^ x2; x2 = ~x2;
    o[0] = x0 ^ rotr(x0, 19) ^ rotr(x0, 28);
    o[1] = x1 ^ rotr(x1, 61) ^ rotr(x1, 39);
    o[2] = x2 ^ rotr(x2, 1)  ^ rotr(x2, 6);
    o[3] = x3 ^ rotr(x3, 10) ^ rotr(x3, 17);
    o[4] = x4 ^ rotr(x4, 7)  ^ rotr(x4, 41);
    return o;
  endfunction

endpackage

// File: sv/asc_if.sv
// Handshake interfaces for input items, result items and configuration writes.
interface asc_in_if;
  logic               valid;
  logic               ready;
  asc_pkg::in_item_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface asc_out_if;
  logic               valid;
  logic               ready;
  asc_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface asc_cfg_if;
  logic                valid;
  logic                ready;
  asc_pkg::cfg_write_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: sv/asc_ctrl.sv
// Sequencing controller: phase tracking, round counter and result handshake.
module asc_ctrl #(
  parameter int INIT_ROUNDS  = asc_pkg::INIT_ROUNDS_DEF,
  parameter int BLOCK_ROUNDS = asc_pkg::BLOCK_ROUNDS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  asc_pkg::in_item_t item,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output asc_pkg::cmd_t     cmd
);
  import asc_pkg::*;

  localparam logic [ROUND_W-1:0] INIT_START  = ROUND_W'(MAX_ROUNDS - INIT_ROUNDS);
  localparam logic [ROUND_W-1:0] BLOCK_START = ROUND_W'(MAX_ROUNDS - BLOCK_ROUNDS);
  localparam logic [ROUND_W-1:0] LAST_ROUND  = ROUND_W'(MAX_ROUNDS - 1);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_ROUND = 2'b10
  } state_t;

  typedef enum logic [2:0] {
    PH_NONCE_HIGH = 3'd0,
    PH_NONCE_LOW  = 3'd1,
    PH_AD_OR_CT   = 3'd2,
    PH_AD_FULL    = 3'd3,
    PH_AD_DONE    = 3'd4,
    PH_CT_FULL    = 3'd5,
    PH_CT_DONE    = 3'd6,
    PH_TAG_LOW    = 3'd7
  } phase_t;

  state_t             state, state_next;
  phase_t             phase, phase_next;
  logic [ROUND_W-1:0] rnd, rnd_next;
  logic               post, post_next;
  action_t            act;
  logic               full, perm, perm_post, ct_first, gives_result, accept;
  logic [ROUND_W-1:0] start;

  always_comb begin
    full      = item.valid_bytes >= 4'(BLOCK_BYTES);
    act       = A_ERROR;
    phase_next = PH_NONCE_HIGH;
    perm      = 1'b0;
    perm_post = 1'b0;
    start     = BLOCK_START;
    ct_first  = 1'b0;
    case (item.operation)
      OP_NONCE_HIGH: begin
        if (phase == PH_NONCE_HIGH) begin
          act = A_NONCE_HIGH;
          phase_next = PH_NONCE_LOW;
        end
      end
      OP_NONCE_LOW: begin
        if (phase == PH_NONCE_LOW) begin
          act = A_INIT;
          phase_next = PH_AD_OR_CT;
          perm = 1'b1;
          perm_post = 1'b1;
          start = INIT_START;
        end
      end
      OP_AD: begin
        if (phase == PH_AD_OR_CT || phase == PH_AD_FULL) begin
          act = A_AD;
          phase_next = full ? PH_AD_FULL : PH_AD_DONE;
          perm = 1'b1;
        end
      end
      OP_CT: begin
        if (phase == PH_AD_OR_CT || phase == PH_AD_DONE || phase == PH_CT_FULL) begin
          act = A_CT;
          ct_first = (phase != PH_CT_FULL);
          phase_next = full ? PH_CT_FULL : PH_CT_DONE;
          perm = full;
        end
      end
      OP_TAG_HIGH: begin
        if (phase == PH_CT_DONE) begin
          act = A_FINAL;
          phase_next = PH_TAG_LOW;
          perm = 1'b1;
          perm_post = 1'b1;
          start = INIT_START;
        end
      end
      OP_TAG_LOW: begin
        if (phase == PH_TAG_LOW) begin
          act = A_TAG;
          phase_next = PH_NONCE_HIGH;
        end
      end
      default: begin
        act = A_ERROR;
      end
    endcase
  end

  assign gives_result = (act == A_CT) || (act == A_TAG) || (act == A_ERROR);
  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready || !gives_result);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    rnd_next   = rnd;
    post_next  = post;
    case (state)
      ST_IDLE: begin
        if (accept && perm) begin
          state_next = ST_ROUND;
          rnd_next   = start;
          post_next  = perm_post;
        end
      end
      ST_ROUND: begin
        rnd_next = rnd + 1'b1;
        if (rnd == LAST_ROUND) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= PH_NONCE_HIGH;
      rnd       <= '0;
      post      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      rnd   <= rnd_next;
      post  <= post_next;
      if (accept) phase <= phase_next;
      if (accept && gives_result) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_comb begin
    cmd.load      = accept;
    cmd.action    = act;
    cmd.ct_first  = ct_first;
    cmd.round_en  = (state == ST_ROUND);
    cmd.round_idx = rnd;
    cmd.post_en   = (state == ST_ROUND) && (rnd == LAST_ROUND) && post;
  end

endmodule

// File: sv/asc_datapath.sv
// Datapath: key registers, permutation lanes, round unit and result register.
module asc_datapath #(
  parameter int INIT_ROUNDS  = asc_pkg::INIT_ROUNDS_DEF,
  parameter int BLOCK_ROUNDS = asc_pkg::BLOCK_ROUNDS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  asc_pkg::in_item_t    item,
  input  asc_pkg::cmd_t        cmd,
  input  logic                 cfg_we,
  input  asc_pkg::cfg_write_t  cfg_wr,
  output asc_pkg::out_item_t   result
);
  import asc_pkg::*;

  localparam logic [LANE_W-1:0] IV = {8'h80, 8'h40, 8'(INIT_ROUNDS), 8'(BLOCK_ROUNDS), 32'd0};

  logic [LANE_W-1:0] key_high, key_low, fin_word;
  lanes_t            lanes, round_out;
  logic [3:0]        nb;
  logic              full;
  logic [LANE_W-1:0] m, d, pad;

  assign nb   = (item.valid_bytes > 4'(BLOCK_BYTES)) ? 4'(BLOCK_BYTES) : item.valid_bytes;
  assign full = (nb == 4'(BLOCK_BYTES));
  assign m    = byte_mask(nb);
  assign d    = item.data & m;
  assign pad  = full ? '0 : pad_at(nb[2:0]);

  always_comb begin
    round_out = asc_round(lanes, cmd.round_idx);
    if (cmd.post_en) begin
      round_out[3] = round_out[3] ^ key_high ^ fin_word;
      round_out[4] = round_out[4] ^ key_low;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
      lanes    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_wr.index)
          REG_KEY_HIGH: key_high <= cfg_wr.value;
          REG_KEY_LOW:  key_low  <= cfg_wr.value;
          default: ;
        endcase
      end
      if (cmd.load) begin
        case (cmd.action)
          A_NONCE_HIGH: lanes[3] <= d;
          A_INIT: begin
            lanes[0] <= IV;
            lanes[1] <= key_high;
            lanes[2] <= key_low;
            lanes[4] <= d;
          end
          A_AD:  lanes[0] <= lanes[0] ^ d ^ pad;
          A_CT: begin
            lanes[4] <= lanes[4] ^ {{(LANE_W-1){1'b0}}, cmd.ct_first};
            lanes[0] <= full ? d : (((lanes[0] & ~m) | d) ^ pad);
          end
          A_FINAL: begin
            lanes[1] <= lanes[1] ^ key_high;
            lanes[2] <= lanes[2] ^ key_low;
          end
          A_TAG: lanes[4] <= lanes[4] ^ d;
          default: ;
        endcase
      end else if (cmd.round_en) begin
        lanes <= round_out;
      end
    end
  end

  // tag word for the finalisation xor; zero for initialisation
  always_ff @(posedge clk) begin
    if (cmd.load && cmd.action == A_INIT)  fin_word <= '0;
    if (cmd.load && cmd.action == A_FINAL) fin_word <= d;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      case (cmd.action)
        A_CT: begin
          result.result_kind <= KIND_PLAIN;
          result.plaintext   <= (lanes[0] & m) ^ d;
          result.plain_bytes <= nb;
          result.tag_ok      <= 1'b0;
        end
        A_TAG: begin
          result.result_kind <= KIND_VERDICT;
          result.plaintext   <= '0;
          result.plain_bytes <= '0;
          result.tag_ok      <= ((lanes[3] | (lanes[4] ^ d)) == '0);
        end
        A_ERROR: begin
          result.result_kind <= KIND_ERROR;
          result.plaintext   <= '0;
          result.plain_bytes <= '0;
          result.tag_ok      <= 1'b0;
        end
        default: ;
      endcase
    end
  end

endmodule

// File: sv/ascon128_aead_decrypt_top.sv
// Ascon-128 decryption top level: controller, datapath and channel ports.
// Latency: a result is offered the cycle after its request is taken.
// Rounds: nonce high, tag low, final ciphertext and errors run none; associated data
//   and full ciphertext blocks run BLOCK_ROUNDS, nonce low and tag high INIT_ROUNDS,
//   one round per cycle; no new request is taken until the rounds are done.
// Reset: synchronous, active high; clears phase, lanes, key and output valid.
module ascon128_aead_decrypt_top #(
  parameter int INIT_ROUNDS  = asc_pkg::INIT_ROUNDS_DEF,
  parameter int BLOCK_ROUNDS = asc_pkg::BLOCK_ROUNDS_DEF
) (
  input logic       clk,
  input logic       rst,
  asc_in_if.sink    cmd,
  asc_out_if.source rsp,
  asc_cfg_if.sink   cfg
);
  import asc_pkg::*;

  cmd_t ctrl_cmd;

  // Key writes are taken unchecked; user must send them only while block is idle.
  assign cfg.ready = 1'b1;

  // Controller: decodes each request against the phase, paces the rounds
  // and holds the result until the sink takes it.
  asc_ctrl #(
    .INIT_ROUNDS  (INIT_ROUNDS),
    .BLOCK_ROUNDS (BLOCK_ROUNDS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .item      (cmd.payload),
    .in_ready  (cmd.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (ctrl_cmd)
  );

  // Datapath: lanes, one round unit and the result register.
  asc_datapath #(
    .INIT_ROUNDS  (INIT_ROUNDS),
    .BLOCK_ROUNDS (BLOCK_ROUNDS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (cmd.payload),
    .cmd    (ctrl_cmd),
    .cfg_we (cfg.valid),
    .cfg_wr (cfg.payload),
    .result (rsp.payload)
  );

endmodule

// File: sv/asc_checker.sv
// Port-level checker for the Ascon-128 decryption top level, with its bind.
module asc_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input asc_pkg::out_item_t out_payload
);
  import asc_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered after reset");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_payload.result_kind == KIND_PLAIN ||
                  out_payload.result_kind == KIND_VERDICT ||
                  out_payload.result_kind == KIND_ERROR)
    else $error("bad result kind");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_payload.result_kind == KIND_ERROR |->
      out_payload.plaintext == '0 && out_payload.plain_bytes == '0 && !out_payload.tag_ok)
    else $error("error result carries data");

  a_plain: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_payload.result_kind == KIND_PLAIN |->
      out_payload.plain_bytes <= 4'(BLOCK_BYTES) && !out_payload.tag_ok)
    else $error("plaintext result malformed");

endmodule

bind ascon128_aead_decrypt_top asc_checker u_chk (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (rsp.valid),
  .out_ready   (rsp.ready),
  .out_payload (rsp.payload)
);

// File: bench/tb_ascon128_aead_decrypt_top.sv
// Self-checking bench for the Ascon-128 decryption block: directed table, random messages.
module tb_ascon128_aead_decrypt_top;
  timeunit 1ns;
  timeprecision 1ps;

  import asc_pkg::*;

  localparam int RESET_CYCLES    = 7;
  localparam int KEY_PHASES      = 6;
  localparam int ITEMS_PER_PHASE = 70;
  localparam int HOLD_CYCLES     = 300;
  // worst single request is nonce low or tag high, which run the long permutation
  localparam int SETTLE_CYCLES   = 2 * (1 + INIT_ROUNDS_DEF);
  localparam int WATCHDOG_LIMIT  = 3000;

  // operation codes the block must reject
  localparam logic [2:0] OP_BAD_6 = 3'd6;
  localparam logic [2:0] OP_BAD_7 = 3'd7;

  localparam logic [LANE_W-1:0] ONES = '1;

  // position in the request sequence, as tracked by the predictor
  typedef enum logic [2:0] {
    WAIT_NONCE_HI,
    WAIT_NONCE_LO,
    WAIT_AD_OR_CT,
    IN_AD,
    AD_DONE,
    IN_CT,
    CT_DONE,
    WAIT_TAG_LO
  } seq_phase_t;

  typedef logic [NUM_LANES-1:0][LANE_W-1:0] sponge_t;

  typedef struct packed {
    in_item_t  req;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  localparam out_item_t SEQ_ERR   = '{KIND_ERROR, 64'd0, 4'd0, 1'b0};
  localparam out_item_t EMPTY_PT  = '{KIND_PLAIN, 64'd0, 4'd0, 1'b0};
  localparam out_item_t UNTYPED   = '0;
  localparam int        DIRECTED_ROWS = 25;

  // Directed requests. Rows with typed set carry their result; the rest take the predictor's result.
  localparam dir_row_t DIRECTED [DIRECTED_ROWS] = '{
    // tag low straight after reset is out of order
    '{'{OP_TAG_LOW,    ONES,                  4'd8},  1'b1, SEQ_ERR},
    // unused operation codes, one with a byte count above a full block
    '{'{OP_BAD_7,      ONES,                  4'd15}, 1'b1, SEQ_ERR},
    '{'{OP_BAD_6,      64'd0,                 4'd0},  1'b1, SEQ_ERR},
    // whole-block associated data not closed before ciphertext
    '{'{OP_NONCE_HIGH, ONES,                  4'd8},  1'b0, UNTYPED},
    '{'{OP_NONCE_LOW,  64'd0,                 4'd15}, 1'b0, UNTYPED},
    '{'{OP_AD,         ONES,                  4'd8},  1'b0, UNTYPED},
    '{'{OP_CT,         ONES,                  4'd8},  1'b1, SEQ_ERR},
    // no associated data and an empty plaintext
    '{'{OP_NONCE_HIGH, 64'h0123_4567_89ab_cdef, 4'd8}, 1'b0, UNTYPED},
    '{'{OP_NONCE_LOW,  ONES,                  4'd8},  1'b0, UNTYPED},
    '{'{OP_CT,         ONES,                  4'd0},  1'b1, EMPTY_PT},
    '{'{OP_TAG_HIGH,   64'd0,                 4'd8},  1'b0, UNTYPED},
    '{'{OP_TAG_LOW,    64'd0,                 4'd8},  1'b0, UNTYPED},
    // data beyond the byte count must be dropped; whole-block AD closed by an empty one
    '{'{OP_NONCE_HIGH, ONES,                  4'd3},  1'b0, UNTYPED},
    '{'{OP_NONCE_LOW,  ONES,                  4'd8},  1'b0, UNTYPED},
    '{'{OP_AD,         ONES,                  4'd8},  1'b0, UNTYPED},
    '{'{OP_AD,         64'd0,                 4'd0},  1'b0, UNTYPED},
    '{'{OP_CT,         ONES,                  4'd8},  1'b0, UNTYPED},
    // tag high before the final ciphertext block
    '{'{OP_TAG_HIGH,   ONES,                  4'd8},  1'b1, SEQ_ERR},
    // partial AD, a full block counted above eight, then a short final block
    '{'{OP_NONCE_HIGH, 64'd0,                 4'd8},  1'b0, UNTYPED},
    '{'{OP_NONCE_LOW,  64'd0,                 4'd8},  1'b0, UNTYPED},
    '{'{OP_AD,         64'hdead_beef_cafe_f00d, 4'd5}, 1'b0, UNTYPED},
    '{'{OP_CT,         ONES,                  4'd12}, 1'b0, UNTYPED},
    '{'{OP_CT,         64'h8899_aabb_ccdd_eeff, 4'd7}, 1'b0, UNTYPED},
    '{'{OP_TAG_HIGH,   ONES,                  4'd8},  1'b0, UNTYPED},
    '{'{OP_TAG_LOW,    ONES,                  4'd8},  1'b0, UNTYPED}
  };

  logic clk = 1'b0;
  logic rst;

  asc_in_if  cmd_ch ();
  asc_out_if rsp_ch ();
  asc_cfg_if cfg_ch ();

  ascon128_aead_decrypt_top dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state: sponge lanes, sequence position and the key as last written
  sponge_t           sponge;
  seq_phase_t        seq;
  logic [LANE_W-1:0] key_hi;
  logic [LANE_W-1:0] key_lo;

  out_item_t   due_results [$];
  int unsigned fail_count   = 0;
  int unsigned items_taken  = 0;
  int unsigned burst_left   = 0;
  int unsigned hold_trigger = 0;
  int unsigned quiet_cycles = 0;

  function automatic logic [LANE_W-1:0] ror64(input logic [LANE_W-1:0] x, input int unsigned n);
    return (x >> n) | (x << (LANE_W - n));
  endfunction

  // run the last nr of the twelve rounds over s
  function automatic sponge_t permute(input sponge_t s, input int unsigned nr);
    logic [LANE_W-1:0] x0, x1, x2, x3, x4, t0, t1, t2, t3, t4;
    for (int unsigned r = MAX_ROUNDS - nr; r < MAX_ROUNDS; r++) begin
      x0 = s[0]; x1 = s[1]; x2 = s[2]; x3 = s[3]; x4 = s[4];
      x2 ^= {56'd0, 4'(15 - r), 4'(r)};
      x0 ^= x4; x4 ^= x3; x2 ^= x1;
      t0 = ~x0 & x1; t1 = ~x1 & x2; t2 = ~x2 & x3; t3 = ~x3 & x4; t4 = ~x4 & x0;
      x0 ^= t1; x1 ^= t2; x2 ^= t3; x3 ^= t4; x4 ^= t0;
      x1 ^= x0; x0 ^= x4; x3 ^= x2; x2 = ~x2;
      s[0] = x0 ^ ror64(x0, 19) ^ ror64(x0, 28);
      s[1] = x1 ^ ror64(x1, 61) ^ ror64(x1, 39);
      s[2] = x2 ^ ror64(x2, 1)  ^ ror64(x2, 6);
      s[3] = x3 ^ ror64(x3, 10) ^ ror64(x3, 17);
      s[4] = x4 ^ ror64(x4, 7)  ^ ror64(x4, 41);
    end
    return s;
  endfunction

  function automatic logic [LANE_W-1:0] lead_mask(input logic [3:0] nb);
    if (nb == 4'd0) return '0;
    return ONES << (LANE_W - 8 * int'(nb));
  endfunction

  function automatic logic [LANE_W-1:0] pad_byte_at(input logic [3:0] nb);
    return {56'd0, PAD_BYTE} << (56 - 8 * int'(nb));
  endfunction

  // Advance the predicted state by one request; return 1 when it yields a result.
  function automatic bit decrypt_word(input in_item_t req, output out_item_t res);
    logic [3:0]        nb;
    logic [LANE_W-1:0] m;
    logic [LANE_W-1:0] d;
    logic [2:0]        op;
    op  = req.operation;
    nb  = (req.valid_bytes > 4'd8) ? 4'd8 : req.valid_bytes;
    m   = lead_mask(nb);
    d   = req.data & m;
    res = '0;
    if (op == OP_NONCE_HIGH && seq == WAIT_NONCE_HI) begin
      sponge[3] = d;
      seq = WAIT_NONCE_LO;
      return 1'b0;
    end
    if (op == OP_NONCE_LOW && seq == WAIT_NONCE_LO) begin
      sponge[0] = {8'h80, 8'h40, 8'(INIT_ROUNDS_DEF), 8'(BLOCK_ROUNDS_DEF), 32'd0};
      sponge[1] = key_hi;
      sponge[2] = key_lo;
      sponge[4] = d;
      sponge = permute(sponge, INIT_ROUNDS_DEF);
      sponge[3] ^= key_hi;
      sponge[4] ^= key_lo;
      seq = WAIT_AD_OR_CT;
      return 1'b0;
    end
    if (op == OP_AD && (seq == WAIT_AD_OR_CT || seq == IN_AD)) begin
      sponge[0] ^= d;
      if (nb < 4'd8) begin
        sponge[0] ^= pad_byte_at(nb);
        seq = AD_DONE;
      end else begin
        seq = IN_AD;
      end
      sponge = permute(sponge, BLOCK_ROUNDS_DEF);
      return 1'b0;
    end
    if (op == OP_CT && (seq == WAIT_AD_OR_CT || seq == AD_DONE || seq == IN_CT)) begin
      // flip the domain bit on the first ciphertext request
      if (seq != IN_CT) sponge[4] ^= 64'd1;
      res.result_kind = KIND_PLAIN;
      res.plaintext   = (sponge[0] ^ d) & m;
      res.plain_bytes = nb;
      if (nb < 4'd8) begin
        sponge[0] = ((sponge[0] & ~m) | d) ^ pad_byte_at(nb);
        seq = CT_DONE;
      end else begin
        sponge[0] = d;
        sponge = permute(sponge, BLOCK_ROUNDS_DEF);
        seq = IN_CT;
      end
      return 1'b1;
    end
    if (op == OP_TAG_HIGH && seq == CT_DONE) begin
      sponge[1] ^= key_hi;
      sponge[2] ^= key_lo;
      sponge = permute(sponge, INIT_ROUNDS_DEF);
      sponge[3] ^= key_hi ^ d;
      sponge[4] ^= key_lo;
      seq = WAIT_TAG_LO;
      return 1'b0;
    end
    if (op == OP_TAG_LOW && seq == WAIT_TAG_LO) begin
      sponge[4] ^= d;
      res.result_kind = KIND_VERDICT;
      res.tag_ok      = ((sponge[3] | sponge[4]) == '0);
      seq = WAIT_NONCE_HI;
      return 1'b1;
    end
    // anything else is out of order: lanes stay, sequence restarts
    res.result_kind = KIND_ERROR;
    seq = WAIT_NONCE_HI;
    return 1'b1;
  endfunction

  function automatic logic [LANE_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // full block count, now and then above eight
  function automatic logic [3:0] full_nb();
    return ($urandom_range(0, 3) == 0) ? 4'($urandom_range(9, 15)) : 4'd8;
  endfunction

  // Offer one request, in bursts with random gaps; predict once it is taken.
  task automatic send_item(input in_item_t req, input bit typed = 1'b0,
                           input out_item_t want = '0);
    out_item_t res;
    int        gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 12);
    end
    burst_left--;
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.payload <= req;
    cmd_ch.valid   <= 1'b1;
    do @(posedge clk); while (!cmd_ch.ready);
    items_taken++;
    if (decrypt_word(req, res)) due_results.push_back(typed ? want : res);
  endtask

  // In a noisy message, now and then slip a random request in ahead of the real one.
  task automatic msg_item(input bit noisy, input logic [2:0] op, input logic [LANE_W-1:0] d,
                          input logic [3:0] nb);
    if (noisy && $urandom_range(0, 5) == 0)
      send_item('{3'($urandom_range(0, 7)), rand64(), 4'($urandom_range(0, 15))});
    send_item('{op, d, nb});
  endtask

  // One message with random content; the tag is right, off by one bit, or random.
  task automatic send_message();
    bit           noisy;
    int           n_full;
    int           pick;
    sponge_t      s;
    logic [127:0] tag;
    noisy = ($urandom_range(0, 5) == 0);
    msg_item(noisy, OP_NONCE_HIGH, rand64(), full_nb());
    msg_item(noisy, OP_NONCE_LOW, rand64(), full_nb());
    // associated data is left out entirely about a third of the time
    if ($urandom_range(0, 2) != 0) begin
      n_full = $urandom_range(0, 3);
      repeat (n_full) msg_item(noisy, OP_AD, rand64(), full_nb());
      msg_item(noisy, OP_AD, rand64(), 4'($urandom_range(0, 7)));
    end
    n_full = $urandom_range(0, 4);
    repeat (n_full) msg_item(noisy, OP_CT, rand64(), full_nb());
    msg_item(noisy, OP_CT, rand64(), 4'($urandom_range(0, 7)));
    // work out the tag that the current state would accept
    s = sponge;
    s[1] ^= key_hi;
    s[2] ^= key_lo;
    s = permute(s, INIT_ROUNDS_DEF);
    tag  = {s[3] ^ key_hi, s[4] ^ key_lo};
    pick = $urandom_range(0, 9);
    if (pick >= 8) tag = {rand64(), rand64()};
    else if (pick >= 5) tag ^= 128'd1 << $urandom_range(0, 127);
    msg_item(noisy, OP_TAG_HIGH, tag[127:64], full_nb());
    msg_item(noisy, OP_TAG_LOW, tag[63:0], full_nb());
  endtask

  // Drop valid, wait for every awaited result, then let the last permutation finish.
  task automatic settle();
    cmd_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both key registers back to back; valid stays high between them.
  task automatic write_keys(input logic [LANE_W-1:0] hi, input logic [LANE_W-1:0] lo);
    cfg_ch.payload <= '{REG_KEY_HIGH, hi};
    cfg_ch.valid   <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    key_hi = hi;
    cfg_ch.payload <= '{REG_KEY_LOW, lo};
    do @(posedge clk); while (!cfg_ch.ready);
    key_lo = lo;
    cfg_ch.valid <= 1'b0;
  endtask

  // Result side: alternate between always ready, mostly ready and mostly stalled, and
  // hold off for a long stretch whenever the stimulus asks for back-pressure.
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    int hold_seen;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    hold_seen = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_trigger) begin
        hold_seen = hold_trigger;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(8, 64);
        end
        mode_left--;
        case (mode)
          0: rsp_ch.ready <= 1'b1;
          1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
          default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Compare every result taken with the oldest one awaited, field by field.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      out_item_t want;
      if (due_results.size() == 0) begin
        $error("unexpected result: result_kind %0d", rsp_ch.payload.result_kind);
        fail_count++;
      end else begin
        want = due_results.pop_front();
        if (rsp_ch.payload.result_kind !== want.result_kind) begin
          $error("result_kind: expected %0d, got %0d", want.result_kind,
                 rsp_ch.payload.result_kind);
          fail_count++;
        end
        if (rsp_ch.payload.plaintext !== want.plaintext) begin
          $error("plaintext: expected %h, got %h", want.plaintext, rsp_ch.payload.plaintext);
          fail_count++;
        end
        if (rsp_ch.payload.plain_bytes !== want.plain_bytes) begin
          $error("plain_bytes: expected %0d, got %0d", want.plain_bytes,
                 rsp_ch.payload.plain_bytes);
          fail_count++;
        end
        if (rsp_ch.payload.tag_ok !== want.tag_ok) begin
          $error("tag_ok: expected %0d, got %0d", want.tag_ok, rsp_ch.payload.tag_ok);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: give up once no channel has moved anything for too long.
  always @(posedge clk) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    // drive every input to a known value and hold reset
    rst            <= 1'b1;
    cmd_ch.valid   <= 1'b0;
    cmd_ch.payload <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.payload <= '0;
    sponge = '0;
    seq    = WAIT_NONCE_HI;
    key_hi = '0;
    key_lo = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed table, run with the key as left by reset
    foreach (DIRECTED[i]) send_item(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].want);

    // random messages under a fresh key each phase, extremes first and last
    for (int p = 0; p < KEY_PHASES; p++) begin
      settle();
      case (p)
        0: write_keys(ONES, ONES);
        1: write_keys(ONES, '0);
        2: write_keys('0, ONES);
        KEY_PHASES - 1: write_keys('0, '0);
        default: write_keys(rand64(), rand64());
      endcase
      // starve the result side for a while so the block backs up into its input
      if (p == 2 || p == 4) hold_trigger++;
      while (items_taken < DIRECTED_ROWS + (p + 1) * ITEMS_PER_PHASE) send_message();
    end

    settle();
    if (fail_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: sim.f
sv/asc_pkg.sv
sv/asc_if.sv
sv/asc_ctrl.sv
sv/asc_datapath.sv
sv/ascon128_aead_decrypt_top.sv
sv/asc_checker.sv
bench/tb_ascon128_aead_decrypt_top.sv
